/* hdl/dalq_pkg.sv */
// package: sizes, register indexes and the channel row type of the detection alarm qualifier
`timescale 1ns / 1ps
package dalq_pkg;

  localparam int CHANNELS   = 4;
  localparam int CLASSES    = 16;
  localparam int COUNT_BITS = 8;

  localparam int MASK_W  = 16;
  localparam int NCLS    = (CLASSES < MASK_W) ? CLASSES : MASK_W;
  localparam int CH_W    = 2;
  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TICK_W  = 32;
  localparam int NEED_W  = 8;
  localparam int LEN_W   = 16;
  localparam int CMP_W   = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WATCH_MASK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_NEEDED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_TICKS = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [MASK_W-1:0] mask_t;

  typedef struct packed {
    count_t [NCLS-1:0]  counts;
    mask_t              suppressed;
    mask_t              pending;
    logic               seg_open;
    logic [TICK_W-1:0]  seg_end;
  } row_t;

endpackage

/* hdl/detection_alarm_qualifier_top.sv */
// top level: per-channel detection qualifying, segment timing and alarm results
`timescale 1ns / 1ps
// Takes one beat per clock cycle, frames and ticks alike, as long as the result
// side keeps up. An accepted frame is held in the stage-one registers, and its
// result is then captured in the output register; a tick, or a frame on a
// channel beyond the configured count, gives no result. Each frame reads its
// channel row (run counts, suppressed and pending classes, segment state) from
// a registered-read memory and writes it back as it leaves stage one; a frame
// on the same channel right behind it gets the written row forwarded. Rows read
// as all zero after reset until first written, so no clearing pass is needed.
// Configuration writes are always taken and are meant for idle periods only.
module detection_alarm_qualifier_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [dalq_pkg::CH_W-1:0]       in_channel,
  input  logic [dalq_pkg::MASK_W-1:0]     in_class_mask,
  input  logic                            in_recorder_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dalq_pkg::MASK_W-1:0]     out_fired_classes,
  output logic                            out_alarm_now,
  output logic                            out_segment_started,
  output logic                            out_segment_closed,
  output logic [dalq_pkg::MASK_W-1:0]     out_segment_classes,
  output logic                            out_recording,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dalq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dalq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dalq_pkg::*;

  row_t                mem [CHANNELS];
  logic [CHANNELS-1:0] row_valid_r;

  logic [MASK_W-1:0] watch_mask_r;
  logic [NEED_W-1:0] frames_needed_r;
  logic [LEN_W-1:0]  segment_ticks_r;
  logic [TICK_W-1:0] now_ticks_r;

  logic              s1_valid_r;
  logic [CH_AW-1:0]  s1_addr_r;
  mask_t             s1_mask_r;
  logic              s1_rec_ready_r;
  row_t              rd_row_r;
  logic              rd_hit_r;
  logic              fwd_hit_r;
  row_t              wr_row_r;

  logic              out_valid_r;
  mask_t             out_fired_r;
  logic              out_alarm_r;
  logic              out_started_r;
  logic              out_closed_r;
  mask_t             out_classes_r;
  logic              out_recording_r;

  logic              s1_go;
  logic              in_accept;
  logic              frame_ok;
  logic [CH_AW-1:0]  in_addr;

  row_t              cur_row;
  row_t              row_nxt;
  mask_t             all_mask;
  mask_t             watched;
  mask_t             seen;
  mask_t             fired;
  mask_t             closed_classes;
  logic              alarm;
  logic              started;
  logic              closed;
  logic [CMP_W-1:0]  need;
  logic [CMP_W-1:0]  len;
  logic [TICK_W-1:0] diff;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_accept = in_valid && in_ready;
  assign in_addr   = CH_AW'(in_channel);
  assign frame_ok  = (in_kind == KIND_FRAME) && (int'(in_channel) < CHANNELS);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (fwd_hit_r) begin
      cur_row = wr_row_r;
    end else if (rd_hit_r) begin
      cur_row = rd_row_r;
    end else begin
      cur_row = '0;
    end
  end

  always_comb begin
    logic [CMP_W-1:0] prev_w;
    logic [CMP_W-1:0] cnt_w;
    all_mask = MASK_W'((64'd1 << NCLS) - 64'd1);
    watched  = (watch_mask_r == '0) ? all_mask : (watch_mask_r & all_mask);
    seen     = s1_mask_r & watched;
    need     = (frames_needed_r == '0) ? CMP_W'(1) : CMP_W'(frames_needed_r);
    len      = (segment_ticks_r == '0) ? CMP_W'(1) : CMP_W'(segment_ticks_r);
    row_nxt  = cur_row;
    fired    = '0;
    alarm    = 1'b0;
    started  = 1'b0;
    closed   = 1'b0;
    closed_classes = '0;
    prev_w   = '0;
    cnt_w    = '0;
    for (int k = 0; k < NCLS; k++) begin
      if (watched[k]) begin
        if (seen[k]) begin
          prev_w = CMP_W'(cur_row.counts[k]);
          if (cur_row.counts[k] != '1) begin
            row_nxt.counts[k] = cur_row.counts[k] + 1'b1;
          end
          cnt_w = CMP_W'(row_nxt.counts[k]);
          if (cnt_w >= need && prev_w < need && !cur_row.suppressed[k]) begin
            fired[k] = 1'b1;
          end
        end else begin
          row_nxt.counts[k] = '0;
        end
      end
    end
    if (fired != '0) begin
      if (!cur_row.seg_open) begin
        row_nxt.pending    = '0;
        row_nxt.suppressed = '0;
        if (s1_rec_ready_r) begin
          row_nxt.seg_open   = 1'b1;
          row_nxt.seg_end    = now_ticks_r + TICK_W'(len);
          row_nxt.pending    = fired;
          row_nxt.suppressed = fired;
          started            = 1'b1;
        end else begin
          alarm = 1'b1;
        end
      end else begin
        row_nxt.pending    = cur_row.pending | fired;
        row_nxt.suppressed = cur_row.suppressed | fired;
      end
    end
    diff = now_ticks_r - row_nxt.seg_end;
    if (row_nxt.seg_open && !diff[TICK_W-1]) begin
      closed             = 1'b1;
      closed_classes     = row_nxt.pending;
      row_nxt.pending    = '0;
      row_nxt.suppressed = '0;
      row_nxt.seg_open   = 1'b0;
    end
  end

  // channel row memory
  always_ff @(posedge clk) begin
    if (s1_go) begin
      mem[s1_addr_r] <= row_nxt;
    end
    if (in_accept) begin
      rd_row_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r     <= '0;
      watch_mask_r    <= '0;
      frames_needed_r <= NEED_W'(1);
      segment_ticks_r <= LEN_W'(10);
      now_ticks_r     <= '0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      rd_hit_r        <= 1'b0;
      fwd_hit_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WATCH_MASK:    watch_mask_r    <= MASK_W'(cfg_data);
          REG_FRAMES_NEEDED: frames_needed_r <= NEED_W'(cfg_data);
          REG_SEGMENT_TICKS: segment_ticks_r <= LEN_W'(cfg_data);
          default: ;
        endcase
      end
      if (in_accept && in_kind == KIND_TICK) begin
        now_ticks_r <= now_ticks_r + 1'b1;
      end
      if (s1_go) begin
        row_valid_r[s1_addr_r] <= 1'b1;
      end
      if (in_accept) begin
        s1_valid_r <= frame_ok;
        rd_hit_r   <= row_valid_r[in_addr];
        fwd_hit_r  <= s1_go && (s1_addr_r == in_addr);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r      <= in_addr;
      s1_mask_r      <= in_class_mask;
      s1_rec_ready_r <= in_recorder_ready;
    end
    if (s1_go) begin
      wr_row_r        <= row_nxt;
      out_fired_r     <= fired;
      out_alarm_r     <= alarm;
      out_started_r   <= started;
      out_closed_r    <= closed;
      out_classes_r   <= closed_classes;
      out_recording_r <= row_nxt.seg_open;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_fired_classes   = out_fired_r;
  assign out_alarm_now       = out_alarm_r;
  assign out_segment_started = out_started_r;
  assign out_segment_closed  = out_closed_r;
  assign out_segment_classes = out_classes_r;
  assign out_recording       = out_recording_r;

endmodule

/* verif/detection_alarm_qualifier_checker.sv */
// checker: predicts each frame's alarm report from accepted beats and compares the result beats
`timescale 1ns / 1ps
module detection_alarm_qualifier_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_kind,
  input  logic [dalq_pkg::CH_W-1:0]       in_channel,
  input  logic [dalq_pkg::MASK_W-1:0]     in_class_mask,
  input  logic                            in_recorder_ready,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [dalq_pkg::MASK_W-1:0]     out_fired_classes,
  input  logic                            out_alarm_now,
  input  logic                            out_segment_started,
  input  logic                            out_segment_closed,
  input  logic [dalq_pkg::MASK_W-1:0]     out_segment_classes,
  input  logic                            out_recording,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dalq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dalq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              reports_owed
);
  import dalq_pkg::*;

  typedef struct packed {
    mask_t fired;
    logic  alarm_now;
    logic  started;
    logic  closed;
    mask_t closed_classes;
    logic  recording;
  } frame_report_t;

  localparam mask_t ALL_CLASSES = {MASK_W{1'b1}} >> (MASK_W - NCLS);

  mask_t              watch_mask_r;
  logic [NEED_W-1:0]  frames_needed_r;
  logic [LEN_W-1:0]   segment_ticks_r;
  count_t             run_count [CHANNELS][NCLS];
  mask_t              suppressed_r [CHANNELS];
  mask_t              pending_r [CHANNELS];
  logic               seg_open_r [CHANNELS];
  logic [TICK_W-1:0]  seg_end_r [CHANNELS];
  logic [TICK_W-1:0]  now_ticks;
  frame_report_t      report_q [$];
  int                 mismatches = 0;

  task automatic qualify_frame(input int ch, input mask_t detected, input logic rec_ready,
                               output frame_report_t rep);
    mask_t             watched;
    mask_t             seen;
    mask_t             fired;
    logic [NEED_W-1:0] need;
    logic [LEN_W-1:0]  len;
    logic [TICK_W-1:0] late;
    count_t            prev;
    rep = '0;
    fired = '0;
    watched = (watch_mask_r == '0) ? ALL_CLASSES : (watch_mask_r & ALL_CLASSES);
    seen = detected & watched;
    need = (frames_needed_r == '0) ? NEED_W'(1) : frames_needed_r;
    for (int k = 0; k < NCLS; k++) begin
      if (watched[k]) begin
        if (seen[k]) begin
          prev = run_count[ch][k];
          if (prev != '1) run_count[ch][k] = prev + 1'b1;
          if (run_count[ch][k] >= need && prev < need && !suppressed_r[ch][k]) fired[k] = 1'b1;
        end else begin
          run_count[ch][k] = '0;
        end
      end
    end
    if (fired != '0) begin
      if (!seg_open_r[ch]) begin
        pending_r[ch] = '0;
        suppressed_r[ch] = '0;
        if (rec_ready) begin
          len = (segment_ticks_r == '0) ? LEN_W'(1) : segment_ticks_r;
          seg_open_r[ch] = 1'b1;
          seg_end_r[ch] = now_ticks + TICK_W'(len);
          pending_r[ch] = fired;
          suppressed_r[ch] = fired;
          rep.started = 1'b1;
        end else begin
          rep.alarm_now = 1'b1;
        end
      end else begin
        pending_r[ch] |= fired;
        suppressed_r[ch] |= fired;
      end
    end
    if (seg_open_r[ch]) begin
      // due once now is at or past the end, in wrapping time
      late = now_ticks - seg_end_r[ch];
      if (!late[TICK_W-1]) begin
        rep.closed = 1'b1;
        rep.closed_classes = pending_r[ch];
        pending_r[ch] = '0;
        suppressed_r[ch] = '0;
        seg_open_r[ch] = 1'b0;
      end
    end
    rep.fired = fired;
    rep.recording = seg_open_r[ch];
  endtask

  task automatic check_field(input string what, input mask_t want, input mask_t got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_beats
    frame_report_t want;
    if (!rst_n) begin
      watch_mask_r = '0;
      frames_needed_r = NEED_W'(1);
      segment_ticks_r = LEN_W'(10);
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < NCLS; k++) run_count[c][k] = '0;
        suppressed_r[c] = '0;
        pending_r[c] = '0;
        seg_open_r[c] = 1'b0;
        seg_end_r[c] = '0;
      end
      now_ticks = '0;
      report_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WATCH_MASK:    watch_mask_r = cfg_data[MASK_W-1:0];
          REG_FRAMES_NEEDED: frames_needed_r = cfg_data[NEED_W-1:0];
          REG_SEGMENT_TICKS: segment_ticks_r = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_TICK) begin
          now_ticks = now_ticks + 1'b1;
        end else if (in_channel < CHANNELS) begin
          qualify_frame(int'(in_channel), in_class_mask, in_recorder_ready, want);
          report_q = {report_q, want};
        end
      end
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t ns: result beat with no report owed, expected none, actual fired %h",
                   $time, out_fired_classes);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          check_field("fired_classes", want.fired, out_fired_classes);
          check_field("alarm_now", mask_t'(want.alarm_now), mask_t'(out_alarm_now));
          check_field("segment_started", mask_t'(want.started), mask_t'(out_segment_started));
          check_field("segment_closed", mask_t'(want.closed), mask_t'(out_segment_closed));
          check_field("segment_classes", want.closed_classes, out_segment_classes);
          check_field("recording", mask_t'(want.recording), mask_t'(out_recording));
        end
      end
    end
    mismatch_count <= mismatches;
    reports_owed <= report_q.size();
  end

endmodule

/* verif/detection_alarm_qualifier_top_test.sv */
// testbench top: clock, reset, frame and tick stimulus, register phases and the verdict
`timescale 1ns / 1ps
module detection_alarm_qualifier_top_test;
  import dalq_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_kind = KIND_FRAME;
  logic [CH_W-1:0]       in_channel = '0;
  mask_t                 in_class_mask = '0;
  logic                  in_recorder_ready = 1'b0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WATCH_MASK;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic                  in_ready;
  logic                  out_valid;
  mask_t                 out_fired_classes;
  logic                  out_alarm_now;
  logic                  out_segment_started;
  logic                  out_segment_closed;
  mask_t                 out_segment_classes;
  logic                  out_recording;
  logic                  cfg_ready;

  int                    mismatch_count;
  int                    reports_owed;
  mask_t                 scene [CHANNELS];
  int                    calm_left = 0;
  int                    ready_hold = 0;
  logic                  ready_level = 1'b1;

  detection_alarm_qualifier_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_channel          (in_channel),
    .in_class_mask       (in_class_mask),
    .in_recorder_ready   (in_recorder_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fired_classes   (out_fired_classes),
    .out_alarm_now       (out_alarm_now),
    .out_segment_started (out_segment_started),
    .out_segment_closed  (out_segment_closed),
    .out_segment_classes (out_segment_classes),
    .out_recording       (out_recording),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  detection_alarm_qualifier_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_channel          (in_channel),
    .in_class_mask       (in_class_mask),
    .in_recorder_ready   (in_recorder_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fired_classes   (out_fired_classes),
    .out_alarm_now       (out_alarm_now),
    .out_segment_started (out_segment_started),
    .out_segment_closed  (out_segment_closed),
    .out_segment_classes (out_segment_classes),
    .out_recording       (out_recording),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .reports_owed        (reports_owed)
  );

  always #5 clk = ~clk;

  // result side stalls: short and long, with stretches of no stall
  always @(posedge clk) begin
    int sel;
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        ready_level = 1'b1;
        ready_hold = $urandom_range(0, 3);
      end else if (sel < 65) begin
        ready_level = 1'b1;
        ready_hold = $urandom_range(20, 80);
      end else if (sel < 92) begin
        ready_level = 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else begin
        ready_level = 1'b0;
        ready_hold = $urandom_range(8, 30);
      end
    end
    out_ready <= ready_level;
  end

  function automatic int pick_gap();
    int sel;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_beat(input logic kind, input logic [CH_W-1:0] ch, input mask_t m,
                           input logic rr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_channel <= ch;
    in_class_mask <= m;
    in_recorder_ready <= rr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
    // ticks leave no report, let them drain
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input mask_t wm, input logic [NEED_W-1:0] need,
                              input logic [LEN_W-1:0] len);
    settle();
    write_reg(REG_WATCH_MASK, CFG_DATA_W'(wm));
    write_reg(REG_FRAMES_NEEDED, CFG_DATA_W'(need));
    write_reg(REG_SEGMENT_TICKS, CFG_DATA_W'(len));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    int              sel;
    logic [CH_W-1:0] ch;
    mask_t           m;
    for (int c = 0; c < CHANNELS; c++) scene[c] = mask_t'($urandom & $urandom);
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) settle();
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        send_beat(KIND_TICK, CH_W'($urandom), mask_t'($urandom), 1'($urandom));
      end else begin
        // classes persist per channel so runs build up, with some noise frames
        ch = CH_W'($urandom_range(0, CHANNELS - 1));
        if ($urandom_range(0, 99) < 35) scene[ch][$urandom_range(0, MASK_W - 1)] ^= 1'b1;
        m = (sel < 36) ? mask_t'($urandom) : scene[ch];
        send_beat(KIND_FRAME, ch, m, $urandom_range(0, 99) < 75);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values: start, join, alarm, close on time
    send_beat(KIND_FRAME, 2'd0, 16'h0001, 1'b1);
    send_beat(KIND_FRAME, 2'd0, 16'h0003, 1'b1);
    send_beat(KIND_FRAME, 2'd1, 16'hFFFF, 1'b0);
    send_beat(KIND_FRAME, 2'd1, 16'hFFFF, 1'b0);
    send_beat(KIND_FRAME, 2'd1, 16'h0000, 1'b1);
    send_beat(KIND_FRAME, 2'd1, 16'h8000, 1'b1);
    for (int i = 0; i < 9; i++) send_beat(KIND_TICK, 2'd3, 16'hFFFF, 1'b1);
    send_beat(KIND_FRAME, 2'd0, 16'h0003, 1'b1);
    send_beat(KIND_TICK, 2'd0, 16'h0000, 1'b0);
    send_beat(KIND_FRAME, 2'd0, 16'h0000, 1'b0);
    send_beat(KIND_FRAME, 2'd1, 16'h8001, 1'b1);
    send_beat(KIND_FRAME, 2'd2, 16'h0000, 1'b1);
    send_beat(KIND_FRAME, 2'd3, 16'hAAAA, 1'b1);
    send_beat(KIND_FRAME, 2'd3, 16'h5555, 1'b0);

    program_regs(16'hFFFF, 8'd1, 16'd1);
    random_phase(110);
    program_regs(16'h0000, 8'd0, 16'd0);
    random_phase(110);
    program_regs(mask_t'($urandom) | 16'h8001, 8'd2, LEN_W'($urandom_range(3, 12)));
    random_phase(110);
    program_regs(mask_t'($urandom), 8'd3, LEN_W'($urandom_range(1, 30)));
    random_phase(110);
    program_regs(mask_t'($urandom), NEED_W'($urandom_range(1, 4)),
                 LEN_W'($urandom_range(2, 15)));
    random_phase(110);

    // long runs up to count saturation
    program_regs(16'h0000, 8'd255, 16'hFFFF);
    for (int i = 0; i < 258; i++) send_beat(KIND_FRAME, 2'd2, 16'h0F0F, 1'b1);
    random_phase(40);

    settle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("detection_alarm_qualifier_top_test: PASS");
    end else begin
      $display("detection_alarm_qualifier_top_test: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("detection_alarm_qualifier_top_test: FAIL");
    $finish;
  end

endmodule

/* detection_alarm_qualifier_top.f */
hdl/dalq_pkg.sv
hdl/detection_alarm_qualifier_top.sv
verif/detection_alarm_qualifier_checker.sv
verif/detection_alarm_qualifier_top_test.sv
